// ----- rtl/core/hbmt_pkg.sv -----
package hbmt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // fixed field widths
    localparam int ID_W    = 32;
    localparam int PORT_W  = 16;
    localparam int HB_W    = 32;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 16;
    localparam int COUNT_W = 6;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic {
        OP_REPORT = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_TICK_DONE = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REMOVE_TIMEOUT = 2'd0,
        REG_SELF_ID        = 2'd1,
        REG_SELF_PORT      = 2'd2,
        REG_UNUSED         = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        op_t                operation;
        logic [ID_W-1:0]    member_id;
        logic [PORT_W-1:0]  member_port;
        logic [HB_W-1:0]    member_heartbeat;
        logic [TIME_W-1:0]  current_time;
    } cmd_word_t;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     entry_id;
        logic [PORT_W-1:0]   entry_port;
        logic [HB_W-1:0]     entry_heartbeat;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } res_word_t;

    // one table row
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PORT_W-1:0]  port;
        logic [HB_W-1:0]    heartbeat;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        entry_t            data;
    } tbl_wr_t;

    typedef struct packed {
        logic hit;
        logic newer;
        logic expired;
    } cmp_res_t;

endpackage

// ----- rtl/core/heartbeat_membership_table_core.sv -----
// channel   ports                                   direction  handshake
// ---------------------------------------------------------------------------
// command   start, busy, cmd (cmd_word_t)           in         start && !busy
// result    strobe, result (res_word_t)             out        strobe, one cycle
// config    wr_en, wr_index, wr_data                in         wr_en, no wait
//
// a report walks the table until its member is found or the rows run out: the
// table sits in one memory with one registered read port, walked one row a cycle
// a tick runs an own-entry search, then a top-down expiry scan; when rows are
// removed, a compaction pass follows
// reset is asynchronous active low; table rows are not cleared, the row count
// alone marks what is valid, so no clearing pass runs
// result words go out one per cycle at most; the receiver cannot stall them
module heartbeat_membership_table_core
    import hbmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_word_t             cmd,
    output logic                  strobe,
    output res_word_t             result,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_W-1:0]      wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_COMPACT,
        S_DONE
    } state_t;

    // configuration registers
    logic [TMO_W-1:0]   remove_timeout_reg;
    logic [ID_W-1:0]    self_id_reg;
    logic [PORT_W-1:0]  self_port_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remove_timeout_reg <= TMO_W'(20);
            self_id_reg        <= '0;
            self_port_reg      <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_REMOVE_TIMEOUT: remove_timeout_reg <= wr_data[TMO_W-1:0];
                REG_SELF_ID:        self_id_reg        <= wr_data[ID_W-1:0];
                REG_SELF_PORT:      self_port_reg      <= wr_data[PORT_W-1:0];
                default:            ;
            endcase
        end
    end

    // sequencer state
    state_t              state_reg,   state_next;
    cmd_word_t           cmd_reg,     cmd_next;
    logic [CNT_W-1:0]    used_reg,    used_next;     // live row count
    logic [CNT_W-1:0]    total_reg,   total_next;    // row count at scan start
    logic [HB_W-1:0]     own_hb_reg,  own_hb_next;
    logic [CNT_W-1:0]    ia_reg,      ia_next;       // read issue counter
    logic [CNT_W-1:0]    wp_reg,      wp_next;       // compaction write pointer
    logic                pv_reg,      pv_next;       // read data valid
    logic [IDX_W-1:0]    pidx_reg,    pidx_next;     // row of read data
    logic [TABLE_DEPTH-1:0] rm_reg,   rm_next;       // rows marked for removal
    logic                strobe_reg,  strobe_next;
    res_word_t           res_reg,     res_next;

    // memory and compare unit hookup
    tbl_wr_t             tbl_wr;
    logic [IDX_W-1:0]    rd_addr;
    entry_t              rd_data;
    cmp_res_t            cmp;
    logic [ID_W-1:0]     key_id;
    logic [PORT_W-1:0]   key_port;
    logic [CNT_W-1:0]    ia_dec;

    hbmt_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // tick searches for our own row, a report for the reported member
    assign key_id   = (cmd_reg.operation == OP_TICK) ? self_id_reg   : cmd_reg.member_id;
    assign key_port = (cmd_reg.operation == OP_TICK) ? self_port_reg : cmd_reg.member_port;

    hbmt_cmp u_cmp (
        .entry     (rd_data),
        .key_id    (key_id),
        .key_port  (key_port),
        .heartbeat (cmd_reg.member_heartbeat),
        .now       (cmd_reg.current_time),
        .timeout   (remove_timeout_reg),
        .res       (cmp)
    );

    assign ia_dec = ia_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        used_next   = used_reg;
        total_next  = total_reg;
        own_hb_next = own_hb_reg;
        ia_next     = ia_reg;
        wp_next     = wp_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        rm_next     = rm_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        rd_addr     = ia_reg[IDX_W-1:0];
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = pidx_reg;
        tbl_wr.data = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    ia_next    = '0;
                    state_next = S_FIND;
                    if (cmd.operation == OP_TICK)
                    begin
                        own_hb_next = own_hb_reg + 1'b1;
                    end
                end
            end

            // linear search, one read issued per cycle
            S_FIND:
            begin
                if (pv_reg && cmp.hit)
                begin
                    tbl_wr.addr = pidx_reg;
                    tbl_wr.data = rd_data;
                    tbl_wr.data.stamp = cmd_reg.current_time;
                    if (cmd_reg.operation == OP_TICK)
                    begin
                        tbl_wr.en = 1'b1;
                        tbl_wr.data.heartbeat = own_hb_reg;
                        ia_next    = used_reg;
                        total_next = used_reg;
                        rm_next    = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        strobe_next              = 1'b1;
                        res_next.entry_id        = rd_data.id;
                        res_next.entry_port      = rd_data.port;
                        res_next.entry_count     = COUNT_W'(used_reg);
                        res_next.last            = 1'b1;
                        state_next               = S_IDLE;
                        if (cmp.newer)
                        begin
                            tbl_wr.en = 1'b1;
                            tbl_wr.data.heartbeat    = cmd_reg.member_heartbeat;
                            res_next.status          = ST_REFRESHED;
                            res_next.entry_heartbeat = cmd_reg.member_heartbeat;
                        end
                        else
                        begin
                            res_next.status          = ST_IGNORED;
                            res_next.entry_heartbeat = rd_data.heartbeat;
                        end
                    end
                end
                else if (ia_reg < used_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = ia_reg[IDX_W-1:0];
                    ia_next   = ia_reg + 1'b1;
                end
                else if (!pv_reg)
                begin
                    // no match in the table
                    if (cmd_reg.operation == OP_TICK)
                    begin
                        ia_next    = used_reg;
                        total_next = used_reg;
                        rm_next    = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        strobe_next              = 1'b1;
                        res_next.entry_id        = cmd_reg.member_id;
                        res_next.entry_port      = cmd_reg.member_port;
                        res_next.entry_heartbeat = cmd_reg.member_heartbeat;
                        res_next.last            = 1'b1;
                        state_next               = S_IDLE;
                        if (used_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            // append at the end
                            tbl_wr.en             = 1'b1;
                            tbl_wr.addr           = used_reg[IDX_W-1:0];
                            tbl_wr.data.id        = cmd_reg.member_id;
                            tbl_wr.data.port      = cmd_reg.member_port;
                            tbl_wr.data.heartbeat = cmd_reg.member_heartbeat;
                            tbl_wr.data.stamp     = cmd_reg.current_time;
                            used_next             = used_reg + 1'b1;
                            res_next.status       = ST_ADDED;
                            res_next.entry_count  = COUNT_W'(used_reg + 1'b1);
                        end
                        else
                        begin
                            res_next.status      = ST_FULL;
                            res_next.entry_count = COUNT_W'(used_reg);
                        end
                    end
                end
            end

            // expiry scan from the top row down, removals reported in order
            S_SCAN:
            begin
                rd_addr = ia_dec[IDX_W-1:0];
                if (pv_reg && cmp.expired)
                begin
                    rm_next[pidx_reg]        = 1'b1;
                    used_next                = used_reg - 1'b1;
                    strobe_next              = 1'b1;
                    res_next.status          = ST_REMOVED;
                    res_next.entry_id        = rd_data.id;
                    res_next.entry_port      = rd_data.port;
                    res_next.entry_heartbeat = rd_data.heartbeat;
                    res_next.entry_count     = COUNT_W'(used_reg - 1'b1);
                    res_next.last            = 1'b0;
                end
                if (ia_reg != '0)
                begin
                    pv_next   = 1'b1;
                    pidx_next = ia_dec[IDX_W-1:0];
                    ia_next   = ia_dec;
                end
                else if (!pv_reg)
                begin
                    ia_next = '0;
                    wp_next = '0;
                    state_next = (used_reg != total_reg) ? S_COMPACT : S_DONE;
                end
            end

            // survivors copied down in order
            S_COMPACT:
            begin
                if (pv_reg && !rm_reg[pidx_reg])
                begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = wp_reg[IDX_W-1:0];
                    tbl_wr.data = rd_data;
                    wp_next     = wp_reg + 1'b1;
                end
                if (ia_reg < total_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = ia_reg[IDX_W-1:0];
                    ia_next   = ia_reg + 1'b1;
                end
                else if (!pv_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                strobe_next              = 1'b1;
                res_next.status          = ST_TICK_DONE;
                res_next.entry_id        = self_id_reg;
                res_next.entry_port      = self_port_reg;
                res_next.entry_heartbeat = own_hb_reg;
                res_next.entry_count     = COUNT_W'(used_reg);
                res_next.last            = 1'b1;
                state_next               = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= '0;
            used_reg   <= '0;
            total_reg  <= '0;
            own_hb_reg <= '0;
            ia_reg     <= '0;
            wp_reg     <= '0;
            pv_reg     <= 1'b0;
            pidx_reg   <= '0;
            rm_reg     <= '0;
            strobe_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            used_reg   <= used_next;
            total_reg  <= total_next;
            own_hb_reg <= own_hb_next;
            ia_reg     <= ia_next;
            wp_reg     <= wp_next;
            pv_reg     <= pv_next;
            pidx_reg   <= pidx_next;
            rm_reg     <= rm_next;
            strobe_reg <= strobe_next;
            res_reg    <= res_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

    // the closing word of an item leaves the block idle, removal words come mid-tick
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.last == !busy))
        else $error("last flag disagrees with busy");

    // row count reported never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.entry_count <= COUNT_W'(TABLE_DEPTH)))
        else $error("entry count beyond table depth");

    // an accepted word always starts a walk
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

endmodule

// ----- rtl/core/hbmt_table.sv -----
module hbmt_table
    import hbmt_pkg::*;
(
    input  logic              clk,
    input  tbl_wr_t           wr,
    input  logic [IDX_W-1:0]  rd_addr,
    output entry_t            rd_data
);

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/hbmt_cmp.sv -----
module hbmt_cmp
    import hbmt_pkg::*;
(
    input  entry_t              entry,
    input  logic [ID_W-1:0]     key_id,
    input  logic [PORT_W-1:0]   key_port,
    input  logic [HB_W-1:0]     heartbeat,
    input  logic [TIME_W-1:0]   now,
    input  logic [TMO_W-1:0]    timeout,
    output cmp_res_t            res
);

    logic [TIME_W-1:0] age;

    // wrapping age
    assign age = now - entry.stamp;

    assign res.hit     = (entry.id == key_id) && (entry.port == key_port);
    assign res.newer   = (entry.heartbeat < heartbeat);
    assign res.expired = (age >= TIME_W'(timeout));

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import hbmt_pkg::*;

    // cycles to let the block settle once its last word is out
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 40;
    // members the traffic generator reports about
    localparam int POOL_SIZE = 48;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    cmd_word_t             cmd;
    logic                  strobe;
    res_word_t             result;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_W-1:0]      wr_data;

    heartbeat_membership_table_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .strobe   (strobe),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // ------------------------------------------------------------------
    // predicted table contents, kept in step with every accepted command
    // ------------------------------------------------------------------
    logic [ID_W-1:0]    tv_id    [TABLE_DEPTH];
    logic [PORT_W-1:0]  tv_port  [TABLE_DEPTH];
    logic [HB_W-1:0]    tv_hb    [TABLE_DEPTH];
    logic [TIME_W-1:0]  tv_stamp [TABLE_DEPTH];
    int                 tv_used;
    logic [HB_W-1:0]    own_hb;

    // register shadows, updated at the edge that writes the register
    logic [TMO_W-1:0]   cfg_tmo;
    logic [ID_W-1:0]    cfg_self_id;
    logic [PORT_W-1:0]  cfg_self_port;

    // result words still owed by the block, oldest first
    res_word_t          awaited_words[$];
    int                 mismatch_count;

    // traffic generator state
    logic [TIME_W-1:0]  now_t;
    logic [ID_W-1:0]    pool_id   [POOL_SIZE];
    logic [PORT_W-1:0]  pool_port [POOL_SIZE];
    logic [HB_W-1:0]    pool_hb   [POOL_SIZE];
    int                 next_new;
    int                 burst_left;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input res_word_t got,
                                   input res_word_t want);
        mismatch_count++;
        $display("%0t ERROR %s: got st=%0d id=%h port=%h hb=%h cnt=%0d last=%0b",
                 $realtime, what, got.status, got.entry_id, got.entry_port,
                 got.entry_heartbeat, got.entry_count, got.last);
        $display("%0t       want st=%0d id=%h port=%h hb=%h cnt=%0d last=%0b",
                 $realtime, want.status, want.entry_id, want.entry_port,
                 want.entry_heartbeat, want.entry_count, want.last);
    endtask

    // ------------------------------------------------------------------
    // result checker: every strobed word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        res_word_t want;
        string     bad;
        if (rst_n && strobe) begin
            if (awaited_words.size() == 0) begin
                report_mismatch("word with nothing pending", result, '0);
            end
            else begin
                want = awaited_words.pop_front();
                bad  = "";
                if (result.status !== want.status)                   bad = {bad, " status"};
                if (result.entry_id !== want.entry_id)               bad = {bad, " id"};
                if (result.entry_port !== want.entry_port)           bad = {bad, " port"};
                if (result.entry_heartbeat !== want.entry_heartbeat) bad = {bad, " heartbeat"};
                if (result.entry_count !== want.entry_count)         bad = {bad, " count"};
                if (result.last !== want.last)                       bad = {bad, " last"};
                if (bad != "")
                    report_mismatch({"field mismatch:", bad}, result, want);
            end
        end
    end

    function automatic int find_row(input logic [ID_W-1:0] id,
                                    input logic [PORT_W-1:0] port);
        int i;
        for (i = 0; i < tv_used; i++)
            if (tv_id[i] == id && tv_port[i] == port)
                return i;
        return -1;
    endfunction

    // apply one accepted command to the table view and queue its words
    task automatic predict_words(input cmd_word_t c);
        int                 row;
        int                 i;
        int                 j;
        logic [TIME_W-1:0]  age;
        res_word_t          w;
        w = '0;
        if (c.operation == OP_REPORT) begin
            row    = find_row(c.member_id, c.member_port);
            w.last = 1'b1;
            if (row >= 0) begin
                // known member: only a strictly higher heartbeat refreshes
                w.status = ST_IGNORED;
                if (tv_hb[row] < c.member_heartbeat) begin
                    tv_hb[row]    = c.member_heartbeat;
                    tv_stamp[row] = c.current_time;
                    w.status      = ST_REFRESHED;
                end
                w.entry_id        = tv_id[row];
                w.entry_port      = tv_port[row];
                w.entry_heartbeat = tv_hb[row];
            end
            else begin
                if (tv_used < TABLE_DEPTH) begin
                    tv_id[tv_used]    = c.member_id;
                    tv_port[tv_used]  = c.member_port;
                    tv_hb[tv_used]    = c.member_heartbeat;
                    tv_stamp[tv_used] = c.current_time;
                    tv_used++;
                    w.status = ST_ADDED;
                end
                else begin
                    // unknown member and no room left: echo the report
                    w.status = ST_FULL;
                end
                w.entry_id        = c.member_id;
                w.entry_port      = c.member_port;
                w.entry_heartbeat = c.member_heartbeat;
            end
            w.entry_count = COUNT_W'(tv_used);
            awaited_words = {awaited_words, w};
        end
        else begin
            own_hb = own_hb + 1'b1;
            row    = find_row(cfg_self_id, cfg_self_port);
            if (row >= 0) begin
                tv_hb[row]    = own_hb;
                tv_stamp[row] = c.current_time;
            end
            // expiry scan from the top row down, compacting as it goes
            for (i = tv_used - 1; i >= 0; i--) begin
                age = c.current_time - tv_stamp[i];
                if (age >= TIME_W'(cfg_tmo)) begin
                    w.status          = ST_REMOVED;
                    w.entry_id        = tv_id[i];
                    w.entry_port      = tv_port[i];
                    w.entry_heartbeat = tv_hb[i];
                    w.last            = 1'b0;
                    for (j = i; j + 1 < tv_used; j++) begin
                        tv_id[j]    = tv_id[j + 1];
                        tv_port[j]  = tv_port[j + 1];
                        tv_hb[j]    = tv_hb[j + 1];
                        tv_stamp[j] = tv_stamp[j + 1];
                    end
                    tv_used--;
                    w.entry_count = COUNT_W'(tv_used);
                    awaited_words = {awaited_words, w};
                end
            end
            w.status          = ST_TICK_DONE;
            w.entry_id        = cfg_self_id;
            w.entry_port      = cfg_self_port;
            w.entry_heartbeat = own_hb;
            w.entry_count     = COUNT_W'(tv_used);
            w.last            = 1'b1;
            awaited_words = {awaited_words, w};
        end
    endtask

    function automatic cmd_word_t make_cmd(input op_t op, input logic [ID_W-1:0] id,
                                           input logic [PORT_W-1:0] port,
                                           input logic [HB_W-1:0] hb,
                                           input logic [TIME_W-1:0] now);
        cmd_word_t c;
        c.operation        = op;
        c.member_id        = id;
        c.member_port      = port;
        c.member_heartbeat = hb;
        c.current_time     = now;
        return c;
    endfunction

    // send one command word; always entered and left at a rising edge
    task automatic send_word(input cmd_word_t c);
        int gap;
        // random gap per word, with occasional back-to-back bursts
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end
        else begin
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(4, 12);
            gap = $urandom_range(0, 17);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // start stays high across back-to-back words
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        predict_words(c);
    endtask

    // stop sending and let every owed word come out
    task automatic drain_block;
        start <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // back-to-back writes of all registers; wr_en stays high throughout
    task automatic set_config(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] sid,
                              input logic [CFG_W-1:0] sport, input bit poke_unused);
        wr_en    <= 1'b1;
        wr_index <= REG_REMOVE_TIMEOUT;
        wr_data  <= tmo;
        @(posedge clk);
        cfg_tmo   = tmo[TMO_W-1:0];
        wr_index <= REG_SELF_ID;
        wr_data  <= sid;
        @(posedge clk);
        cfg_self_id = sid[ID_W-1:0];
        wr_index   <= REG_SELF_PORT;
        wr_data    <= sport;
        @(posedge clk);
        cfg_self_port = sport[PORT_W-1:0];
        if (poke_unused) begin
            // the spare index must leave every register alone
            wr_index <= REG_UNUSED;
            wr_data  <= $urandom;
            @(posedge clk);
        end
        wr_en <= 1'b0;
    endtask

    task automatic advance_time;
        now_t = now_t + $urandom_range(0, 3);
        // rare jump: ages become arbitrary
        if ($urandom_range(0, 49) == 0)
            now_t = $urandom;
    endtask

    // random mix of ticks, well-formed member reports and noise
    task automatic run_traffic(input int count, input int tick_pct, input int new_pct);
        int                n;
        int                r;
        int                k;
        logic [HB_W-1:0]   hb;
        for (n = 0; n < count; n++) begin
            advance_time();
            r = $urandom_range(0, 99);
            if (r < tick_pct) begin
                // member fields are don't-care on a tick
                send_word(make_cmd(OP_TICK, $urandom, PORT_W'($urandom), $urandom, now_t));
            end
            else if (r < tick_pct + 10) begin
                send_word(make_cmd(OP_REPORT, $urandom, PORT_W'($urandom), $urandom, now_t));
            end
            else begin
                if ($urandom_range(0, 99) < new_pct) begin
                    k        = next_new;
                    next_new = (next_new + 1) % POOL_SIZE;
                end
                else begin
                    k = $urandom_range(0, POOL_SIZE - 1);
                end
                if ($urandom_range(0, 9) < 7) begin
                    pool_hb[k] = pool_hb[k] + $urandom_range(1, 4);
                    hb         = pool_hb[k];
                end
                else begin
                    // stale or repeated heartbeat
                    hb = pool_hb[k] - $urandom_range(0, 2);
                end
                send_word(make_cmd(OP_REPORT, pool_id[k], pool_port[k], hb, now_t));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // reset register values; add, refresh, equal and lower heartbeats,
    // same id on another port, field extremes
    task automatic test_report_cases;
        now_t = 32'hFFFF_FFF0;
        send_word(make_cmd(OP_REPORT, '0, '0, '0, now_t));
        send_word(make_cmd(OP_REPORT, '1, '1, '1, now_t));
        now_t = now_t + 3;
        send_word(make_cmd(OP_REPORT, 32'd5, 16'd7, 32'd10, now_t));
        send_word(make_cmd(OP_REPORT, 32'd5, 16'd7, 32'd10, now_t));
        send_word(make_cmd(OP_REPORT, 32'd5, 16'd7, 32'd9, now_t));
        send_word(make_cmd(OP_REPORT, 32'd5, 16'd7, 32'd11, now_t));
        send_word(make_cmd(OP_REPORT, 32'd5, 16'd8, 32'd1, now_t));
        send_word(make_cmd(OP_REPORT, '1, '1, '0, now_t));
        send_word(make_cmd(OP_REPORT, 32'h8000_0000, 16'h8000, 32'h8000_0000, now_t));
    endtask

    // own entry refresh, expiry across the time wrap, removal order
    task automatic test_tick_cases;
        now_t = now_t + 2;
        send_word(make_cmd(OP_TICK, '0, '0, '0, now_t));
        send_word(make_cmd(OP_REPORT, 32'h1234_5678, 16'hA5A5, 32'd3, now_t));
        // time 20 past the first reports: oldest rows reach the timeout
        now_t = 32'h0000_0004;
        send_word(make_cmd(OP_TICK, '1, '1, '1, now_t));
        now_t = 32'h0000_000A;
        send_word(make_cmd(OP_TICK, $urandom, PORT_W'($urandom), $urandom, now_t));
        now_t = now_t + 1;
        send_word(make_cmd(OP_TICK, $urandom, PORT_W'($urandom), $urandom, now_t));
        // far jump: everything but the refreshed own entry expires
        now_t = 32'h7FFF_0000;
        send_word(make_cmd(OP_TICK, $urandom, PORT_W'($urandom), $urandom, now_t));
    endtask

    // longest timeout, own entry among the pool; table fills and overflows
    task automatic test_fill_to_capacity;
        logic [CFG_W-1:0] junk;
        junk = $urandom;
        drain_block();
        set_config({junk[31:16], 16'hFFFF}, pool_id[0], {junk[15:0], pool_port[0]}, 1'b0);
        run_traffic(55, 5, 60);
    endtask

    // timeout of one: anything not stamped at the tick time goes
    task automatic test_fast_expiry;
        logic [CFG_W-1:0] junk;
        junk = $urandom;
        drain_block();
        set_config({junk[31:16], 16'd1}, $urandom, $urandom, 1'b1);
        run_traffic(25, 30, 30);
    endtask

    task automatic test_mixed_traffic;
        drain_block();
        set_config($urandom_range(3, 10), pool_id[1], pool_port[1], 1'b1);
        run_traffic(15, 20, 40);
    endtask

    // zero timeout: every row goes on the next tick
    task automatic test_zero_timeout;
        drain_block();
        set_config('0, '1, '1, 1'b0);
        send_word(make_cmd(OP_TICK, '0, '0, '0, now_t));
        run_traffic(10, 30, 50);
    endtask

    initial begin
        int k;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        cmd            <= '0;
        wr_en          <= 1'b0;
        wr_index       <= REG_REMOVE_TIMEOUT;
        wr_data        <= '0;
        tv_used        = 0;
        own_hb         = '0;
        cfg_tmo        = 16'd20;
        cfg_self_id    = '0;
        cfg_self_port  = '0;
        mismatch_count = 0;
        next_new       = 0;
        burst_left     = 0;
        for (k = 0; k < POOL_SIZE; k++) begin
            pool_id[k]   = $urandom;
            pool_port[k] = PORT_W'($urandom);
            // a few heartbeats sit near the top and wrap
            pool_hb[k]   = (k % 11 == 5) ? 32'hFFFF_FFF8 : $urandom_range(0, 5000);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_report_cases();
        test_tick_cases();
        test_fill_to_capacity();
        test_fast_expiry();
        test_mixed_traffic();
        test_zero_timeout();

        drain_block();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
